// File: src/dadd_pkg.sv
// Shared types, calendar constants and the month length function for the
// date offset unit. No dependencies.
package dadd_pkg;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 16;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [DAY_W-1:0] DAYS_LEAP_FEB = 5'd29;
	localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
	localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;
	localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;

	// Days in a month; leap when the two low year bits are zero
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic [1:0] y_lo);
		logic [DAY_W-1:0] len;
		len = DAYS_LONG;
		if (m == MONTH_FEB) begin
			len = (y_lo == 2'b00) ? DAYS_LEAP_FEB : DAYS_FEB;
		end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
			m == MONTH_NOV) begin
			len = DAYS_SHORT;
		end
		return len;
	endfunction

endpackage

// File: src/date_add_day_offset_unit.sv
// Top level of the date offset unit: sequencer, day accumulator and month stepper.
// Depends on dadd_pkg.
// After an input transaction the unit walks k months before raising out_valid, where k is
// up to about 1100 for 16-bit offsets, one step per cycle in the shared unit.
// A new item is taken only after the last result is taken; in_ready is high only while idle.
// Reset: arst_n clears the sequencer to idle; the datapath registers are not reset.
module date_add_day_offset_unit #(
	parameter int unsigned OFFSET_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dadd_pkg::DAY_W-1:0]          start_day,
	input  logic [dadd_pkg::MONTH_W-1:0]        start_month,
	input  logic [dadd_pkg::YEAR_W-1:0]         start_year,
	input  logic signed [OFFSET_BITS-1:0]       day_offset,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dadd_pkg::DAY_W-1:0]          result_day,
	output logic [dadd_pkg::MONTH_W-1:0]        result_month,
	output logic [dadd_pkg::YEAR_W-1:0]         result_year
);

	// Accumulator holds start day plus offset with headroom for both signs
	localparam int unsigned DW = OFFSET_BITS + 2;

	dadd_pkg::state_t state_q, state_nxt;

	logic signed [DW-1:0]              d_q;
	logic [dadd_pkg::MONTH_W-1:0]      m_q;
	logic [dadd_pkg::YEAR_W-1:0]       y_q;

	logic                              in_fire, out_fire;
	logic [dadd_pkg::DAY_W-1:0]        len_cur, len_prev;
	logic [dadd_pkg::MONTH_W-1:0]      m_prev, m_next, m_start;
	logic [dadd_pkg::YEAR_W-1:0]       y_prev, y_next;
	logic signed [DW-1:0]              len_cur_s, len_prev_s, addend, d_sum, d_start;
	logic                              over, under;

	assign in_fire  = in_valid & in_ready;
	assign out_fire = out_valid & out_ready;

	// Clamp start month into 1..12
	always_comb begin
		m_start = start_month;
		if (start_month < dadd_pkg::MONTH_JAN) begin
			m_start = dadd_pkg::MONTH_JAN;
		end else if (start_month > dadd_pkg::MONTH_DEC) begin
			m_start = dadd_pkg::MONTH_DEC;
		end
	end

	// Initial day: start day plus sign-extended offset
	assign d_start = $signed({{(DW-dadd_pkg::DAY_W){1'b0}}, start_day}) +
		$signed({{2{day_offset[OFFSET_BITS-1]}}, day_offset});

	// Neighbor months and their lengths
	always_comb begin
		if (m_q == dadd_pkg::MONTH_DEC) begin
			m_next = dadd_pkg::MONTH_JAN;
			y_next = y_q + 16'd1;
		end else begin
			m_next = m_q + 4'd1;
			y_next = y_q;
		end
		if (m_q == dadd_pkg::MONTH_JAN) begin
			m_prev = dadd_pkg::MONTH_DEC;
			y_prev = y_q - 16'd1;
		end else begin
			m_prev = m_q - 4'd1;
			y_prev = y_q;
		end
	end

	assign len_cur    = dadd_pkg::month_len(m_q, y_q[1:0]);
	assign len_prev   = dadd_pkg::month_len(m_prev, y_prev[1:0]);
	assign len_cur_s  = $signed({{(DW-dadd_pkg::DAY_W){1'b0}}, len_cur});
	assign len_prev_s = $signed({{(DW-dadd_pkg::DAY_W){1'b0}}, len_prev});

	// Shared add/compare unit: one month step per cycle
	assign over   = d_q > len_cur_s;
	assign under  = d_q < $signed({{(DW-1){1'b0}}, 1'b1});
	assign addend = over ? -len_cur_s : len_prev_s;
	assign d_sum  = d_q + addend;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dadd_pkg::ST_IDLE: begin
				if (in_fire) state_nxt = dadd_pkg::ST_RUN;
			end
			dadd_pkg::ST_RUN: begin
				if (!over && !under) state_nxt = dadd_pkg::ST_DONE;
			end
			dadd_pkg::ST_DONE: begin
				if (out_fire) state_nxt = dadd_pkg::ST_IDLE;
			end
			default: state_nxt = dadd_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			dadd_pkg::ST_IDLE: in_ready  = 1'b1;
			dadd_pkg::ST_DONE: out_valid = 1'b1;
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dadd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Date registers: load on transaction, step while running
	always_ff @(posedge clk) begin
		if (in_fire) begin
			d_q <= d_start;
			m_q <= m_start;
			y_q <= start_year;
		end else if (state_q == dadd_pkg::ST_RUN) begin
			if (over) begin
				d_q <= d_sum;
				m_q <= m_next;
				y_q <= y_next;
			end else if (under) begin
				d_q <= d_sum;
				m_q <= m_prev;
				y_q <= y_prev;
			end
		end
	end

	assign result_day   = d_q[dadd_pkg::DAY_W-1:0];
	assign result_month = m_q;
	assign result_year  = y_q;

	// Finished day lies within a month
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dadd_pkg::ST_DONE |-> (d_q >= 1 && d_q <= 31))
		else $error("result day out of range");

	// Month stays in 1..12 while an item is in flight
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != dadd_pkg::ST_IDLE |-> (m_q >= dadd_pkg::MONTH_JAN &&
		m_q <= dadd_pkg::MONTH_DEC))
		else $error("month out of range");

	// An accepted item always starts the month walk
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == dadd_pkg::ST_RUN)
		else $error("accepted item did not start");

	// Result stays put while waiting to be taken
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(d_q) && $stable(m_q) && $stable(y_q))
		else $error("result changed while pending");

endmodule
